// ----- hw/rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and fixed geometry of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MinOrd   = 5;
  localparam int unsigned MaxOrd   = 16;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned NumBins  = MaxOrd - MinOrd + 1;
  localparam int unsigned BinW     = $clog2(NumBins);
  localparam int unsigned GranW    = MaxOrd - MinOrd;
  localparam int unsigned NumGran  = 1 << GranW;
  localparam int unsigned LinkW    = GranW + 1;
  localparam int unsigned SizeW    = 20;
  localparam int unsigned OffW     = 16;
  localparam int unsigned OrdW     = 5;
  localparam int unsigned MetaW    = BinW + 1;

  // link code for the end of a list
  localparam logic [LinkW-1:0] LinkNull = LinkW'(NumGran);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SEED,
    S_A_FIND,
    S_A_DONE,
    S_UNL,
    S_PUSH,
    S_PUSH2,
    S_F_CHK,
    S_F_BRD,
    S_F_BCHK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             operation;
    logic [SizeW-1:0] request_size;
    logic [OffW-1:0]  user_offset;
  } in_word_t;

  typedef struct packed {
    logic [OffW-1:0] granted_offset;
    logic            ok;
  } out_word_t;

endpackage

// ----- hw/rtl/bba_size_order.sv -----
// ----------------------------------------------------------------------------
// bba_size_order
// Maps an allocate size to its bin index and flags sizes that are refused.
// ----------------------------------------------------------------------------
module bba_size_order (
  input  logic [bba_pkg::SizeW-1:0] request_size_i,
  output logic [bba_pkg::BinW-1:0]  bin_idx_o,
  output logic                      reject_o
);

  localparam int unsigned TotW = bba_pkg::SizeW + 1;

  logic [TotW-1:0] total;
  logic [TotW-1:0] vm1;
  logic [4:0]      blen;

  assign total = TotW'(request_size_i) + TotW'(bba_pkg::HdrBytes);
  assign vm1   = total - TotW'(1);

  always_comb begin
    blen = '0;
    for (int i = 0; i < TotW; i++) begin
      if (vm1[i]) blen = 5'(i + 1);
    end
  end

  assign reject_o = (request_size_i == '0) ||
                    (total > TotW'(64'd1 << bba_pkg::MaxOrd));

  always_comb begin
    if (blen <= 5'(bba_pkg::MinOrd)) begin
      bin_idx_o = '0;
    end else begin
      bin_idx_o = bba_pkg::BinW'(blen - 5'(bba_pkg::MinOrd));
    end
  end

endmodule

// ----- hw/rtl/buddy_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator: per-order free lists in link memories, one sequencer.
// ----------------------------------------------------------------------------
// Allocate: find, unlink, then a push pair per split, then done. Free:
// check, then per merge a buddy read, buddy check and unlink, then a push pair;
// a failed buddy check also ends the merging. One word in flight at a time; the
// sequencer and its one read and one write port per metadata/link memory set
// the pace. Reset and any arena_order write run a clearing pass over all 2048
// granule metadata entries plus a seed step; no word is taken meanwhile.
module buddy_block_allocator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bba_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bba_pkg::out_word_t   out_word_o
);

  localparam int unsigned NB = bba_pkg::NumBins;
  localparam int unsigned BW = bba_pkg::BinW;
  localparam int unsigned GW = bba_pkg::GranW;
  localparam int unsigned LW = bba_pkg::LinkW;
  localparam int unsigned MW = bba_pkg::MetaW;
  localparam int unsigned OW = bba_pkg::OffW;

  bba_pkg::state_e state_q, state_d;
  logic [bba_pkg::OrdW-1:0] arena_q, arena_d;
  logic [LW-1:0] head_q [NB];
  logic [LW-1:0] head_d [NB];
  logic [NB-1:0] map_q, map_d;
  logic [GW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;

  bba_pkg::op_e       op_q, op_d;
  logic [BW-1:0]      idx_q, idx_d, k_q, k_d;
  logic [GW-1:0]      g_q, g_d, bud_q, bud_d, pb_q, pb_d;
  logic [LW-1:0]      nxt_q, nxt_d;
  bba_pkg::out_word_t res_q, res_d, out_word_q, out_word_d;

  // memories
  logic [MW-1:0] meta_mem [bba_pkg::NumGran];
  logic [LW-1:0] prev_mem [bba_pkg::NumGran];
  logic [LW-1:0] next_mem [bba_pkg::NumGran];
  logic          meta_we, prev_we, next_we;
  logic [GW-1:0] meta_wa, prev_wa, next_wa, meta_ra, link_ra;
  logic [MW-1:0] meta_wd, meta_rd_q;
  logic [LW-1:0] prev_wd, next_wd, prev_rd_q, next_rd_q;

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[link_ra];
  end

  // config port
  logic       cfg_we;
  logic [4:0] cfg_v, cfg_clamp;
  assign pready = 1'b1;
  assign prdata = 32'(arena_q);
  assign cfg_we = psel & penable & pwrite & ~paddr[2];
  assign cfg_v  = pwdata[4:0];
  always_comb begin
    if (cfg_v < 5'(bba_pkg::MinOrd)) begin
      cfg_clamp = 5'(bba_pkg::MinOrd);
    end else if (cfg_v > 5'(bba_pkg::MaxOrd)) begin
      cfg_clamp = 5'(bba_pkg::MaxOrd);
    end else begin
      cfg_clamp = cfg_v;
    end
  end

  // handshakes
  logic in_acc, load_ok;
  assign in_stall_o  = (state_q != bba_pkg::S_IDLE);
  assign in_acc      = in_valid_i & (state_q == bba_pkg::S_IDLE);
  assign load_ok     = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // allocate size decode
  logic [BW-1:0] a_idx;
  logic          a_reject;
  bba_size_order u_size (
    .request_size_i (in_word_i.request_size),
    .bin_idx_o      (a_idx),
    .reject_o       (a_reject)
  );

  logic [BW-1:0] top;
  assign top = BW'(arena_q - bba_pkg::OrdW'(bba_pkg::MinOrd));

  // free request checks
  logic [OW-1:0] f_b;
  logic          f_bad;
  logic [OW:0]   f_hi;
  assign f_b   = in_word_i.user_offset - OW'(bba_pkg::HdrBytes);
  assign f_hi  = {1'b0, f_b} >> arena_q;
  assign f_bad = (in_word_i.user_offset < OW'(bba_pkg::HdrBytes)) ||
                 (f_b[bba_pkg::MinOrd-1:0] != '0) || (f_hi != '0);

  // lowest non-empty bin at or above idx
  logic [NB-1:0] a_mask;
  logic [BW-1:0] found;
  logic [LW-1:0] found_head;
  assign a_mask = map_q & ({NB{1'b1}} << idx_q);
  always_comb begin
    found = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (a_mask[i]) found = BW'(i);
    end
  end
  assign found_head = head_q[found];

  // stored order check on free
  logic          c_free;
  logic [BW-1:0] c_ord;
  logic [GW-1:0] c_lowmask;
  logic          c_bad;
  assign c_free = meta_rd_q[MW-1];
  assign c_ord  = meta_rd_q[BW-1:0];
  always_comb begin
    for (int i = 0; i < GW; i++) begin
      c_lowmask[i] = (BW'(i) < c_ord);
    end
  end
  assign c_bad = c_free || (c_ord > top) || ((g_q & c_lowmask) != '0);

  // push operands
  logic [BW-1:0] p_k;
  logic [GW-1:0] p_b;
  logic [LW-1:0] p_nxt;
  assign p_k   = (op_q == bba_pkg::OP_FREE) ? k_q : k_q - BW'(1);
  assign p_b   = (op_q == bba_pkg::OP_FREE) ? g_q : (g_q ^ (GW'(1) << p_k));
  assign p_nxt = map_q[p_k] ? head_q[p_k] : bba_pkg::LinkNull;

  logic [GW-1:0] u_node, merged_g;
  assign u_node   = (op_q == bba_pkg::OP_FREE) ? bud_q : g_q;
  assign merged_g = (bud_q < g_q) ? bud_q : g_q;

  logic bud_match;
  assign bud_match = c_free && (c_ord == k_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.operation == bba_pkg::OP_FREE) begin
            state_d = f_bad ? bba_pkg::S_OUT : bba_pkg::S_F_CHK;
          end else begin
            state_d = a_reject ? bba_pkg::S_OUT : bba_pkg::S_A_FIND;
          end
        end
      end
      bba_pkg::S_CLR:    if (clr_q == '1) state_d = bba_pkg::S_SEED;
      bba_pkg::S_SEED:   state_d = bba_pkg::S_IDLE;
      bba_pkg::S_A_FIND: begin
        state_d = (a_mask == '0 || found_head[LW-1]) ? bba_pkg::S_OUT : bba_pkg::S_UNL;
      end
      bba_pkg::S_UNL: begin
        if (op_q == bba_pkg::OP_FREE) begin
          state_d = (k_q + BW'(1) < top) ? bba_pkg::S_F_BRD : bba_pkg::S_PUSH;
        end else begin
          state_d = (k_q > idx_q) ? bba_pkg::S_PUSH : bba_pkg::S_A_DONE;
        end
      end
      bba_pkg::S_PUSH:   state_d = bba_pkg::S_PUSH2;
      bba_pkg::S_PUSH2: begin
        if (op_q == bba_pkg::OP_FREE) begin
          state_d = bba_pkg::S_OUT;
        end else begin
          state_d = (k_q > idx_q) ? bba_pkg::S_PUSH : bba_pkg::S_A_DONE;
        end
      end
      bba_pkg::S_A_DONE: state_d = bba_pkg::S_OUT;
      bba_pkg::S_F_CHK: begin
        if (c_bad) begin
          state_d = bba_pkg::S_OUT;
        end else begin
          state_d = (c_ord < top) ? bba_pkg::S_F_BRD : bba_pkg::S_PUSH;
        end
      end
      bba_pkg::S_F_BRD:  state_d = bba_pkg::S_F_BCHK;
      bba_pkg::S_F_BCHK: state_d = bud_match ? bba_pkg::S_UNL : bba_pkg::S_PUSH;
      bba_pkg::S_OUT:    if (load_ok) state_d = bba_pkg::S_IDLE;
      default:           state_d = bba_pkg::S_IDLE;
    endcase
    if (cfg_we) state_d = bba_pkg::S_CLR;
  end

  // datapath and memory control
  always_comb begin
    arena_d     = arena_q;
    head_d      = head_q;
    map_d       = map_q;
    clr_d       = clr_q;
    op_d        = op_q;
    idx_d       = idx_q;
    k_d         = k_q;
    g_d         = g_q;
    bud_d       = bud_q;
    pb_d        = pb_q;
    nxt_d       = nxt_q;
    res_d       = res_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    meta_we = 1'b0; meta_wa = '0; meta_wd = '0; meta_ra = g_q;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0; link_ra = g_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      bba_pkg::S_IDLE: begin
        op_d  = bba_pkg::op_e'(in_word_i.operation);
        idx_d = a_idx;
        g_d   = f_b[OW-1:bba_pkg::MinOrd];
        res_d = '0;
        meta_ra = f_b[OW-1:bba_pkg::MinOrd];
      end
      bba_pkg::S_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        clr_d   = clr_q + GW'(1);
      end
      bba_pkg::S_SEED: begin
        meta_we = 1'b1; meta_wa = '0; meta_wd = {1'b1, top};
        prev_we = 1'b1; prev_wa = '0; prev_wd = bba_pkg::LinkNull;
        next_we = 1'b1; next_wa = '0; next_wd = bba_pkg::LinkNull;
        head_d[top] = '0;
        map_d       = NB'(1) << top;
      end
      bba_pkg::S_A_FIND: begin
        g_d     = found_head[GW-1:0];
        k_d     = found;
        link_ra = found_head[GW-1:0];
      end
      bba_pkg::S_UNL: begin
        // take u_node out of bin k_q
        if (!prev_rd_q[LW-1]) begin
          next_we = 1'b1;
          next_wa = prev_rd_q[GW-1:0];
          next_wd = next_rd_q;
        end else begin
          head_d[k_q] = next_rd_q;
          if (next_rd_q[LW-1]) map_d[k_q] = 1'b0;
        end
        if (!next_rd_q[LW-1]) begin
          prev_we = 1'b1;
          prev_wa = next_rd_q[GW-1:0];
          prev_wd = prev_rd_q;
        end
        meta_we = 1'b1;
        meta_wa = u_node;
        meta_wd = {1'b0, k_q};
        if (op_q == bba_pkg::OP_FREE) begin
          g_d = merged_g;
          k_d = k_q + BW'(1);
        end
      end
      bba_pkg::S_PUSH: begin
        meta_we = 1'b1; meta_wa = p_b; meta_wd = {1'b1, p_k};
        prev_we = 1'b1; prev_wa = p_b; prev_wd = bba_pkg::LinkNull;
        next_we = 1'b1; next_wa = p_b; next_wd = p_nxt;
        head_d[p_k] = LW'(p_b);
        map_d[p_k]  = 1'b1;
        k_d   = p_k;
        pb_d  = p_b;
        nxt_d = p_nxt;
      end
      bba_pkg::S_PUSH2: begin
        if (!nxt_q[LW-1]) begin
          prev_we = 1'b1;
          prev_wa = nxt_q[GW-1:0];
          prev_wd = LW'(pb_q);
        end
        if (op_q == bba_pkg::OP_FREE) res_d.ok = 1'b1;
      end
      bba_pkg::S_A_DONE: begin
        meta_we = 1'b1;
        meta_wa = g_q;
        meta_wd = {1'b0, idx_q};
        res_d.granted_offset = {g_q, bba_pkg::MinOrd'(0)} + OW'(bba_pkg::HdrBytes);
        res_d.ok             = 1'b1;
      end
      bba_pkg::S_F_CHK: begin
        k_d = c_ord;
      end
      bba_pkg::S_F_BRD: begin
        bud_d   = g_q ^ (GW'(1) << k_q);
        meta_ra = g_q ^ (GW'(1) << k_q);
      end
      bba_pkg::S_F_BCHK: begin
        link_ra = bud_q;
      end
      bba_pkg::S_OUT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
        end
      end
      default: ;
    endcase

    if (cfg_we) begin
      arena_d = cfg_clamp;
      clr_d   = '0;
      map_d   = '0;
      for (int i = 0; i < NB; i++) head_d[i] = bba_pkg::LinkNull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::S_CLR;
      arena_q     <= bba_pkg::OrdW'(bba_pkg::MaxOrd);
      map_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NB; i++) head_q[i] <= bba_pkg::LinkNull;
    end else begin
      state_q     <= state_d;
      arena_q     <= arena_d;
      map_q       <= map_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    k_q        <= k_d;
    g_q        <= g_d;
    bud_q      <= bud_d;
    pb_q       <= pb_d;
    nxt_q      <= nxt_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

endmodule

// ----- verif/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Watches the register port and both word channels of the buddy allocator.
// It keeps its own copy of the bins, free lists and granule metadata,
// predicts each result word and compares it with what comes out.
// ----------------------------------------------------------------------------
module bba_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  bba_pkg::in_word_t   in_word_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  bba_pkg::out_word_t  out_word_o,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegArenaOrder = 3'd0;

  logic [bba_pkg::OrdW-1:0]    arena_ord;
  logic [bba_pkg::LinkW-1:0]   bin_head[bba_pkg::NumBins];
  logic [bba_pkg::NumBins-1:0] bin_map;
  bit                          gran_free[bba_pkg::NumGran];
  logic [bba_pkg::BinW-1:0]    gran_ord[bba_pkg::NumGran];
  logic [bba_pkg::LinkW-1:0]   link_prev[bba_pkg::NumGran];
  logic [bba_pkg::LinkW-1:0]   link_next[bba_pkg::NumGran];

  bba_pkg::out_word_t expected_words[$];
  int                 fails;

  assign fail_count_o = fails;

  function automatic void push_free(int unsigned g, int unsigned k);
    logic [bba_pkg::LinkW-1:0] nxt;
    if (g >= bba_pkg::NumGran || k >= bba_pkg::NumBins) return;
    nxt = bin_map[k] ? bin_head[k] : bba_pkg::LinkNull;
    gran_free[g] = 1'b1;
    gran_ord[g]  = bba_pkg::BinW'(k);
    link_prev[g] = bba_pkg::LinkNull;
    link_next[g] = nxt;
    if (nxt < bba_pkg::NumGran) link_prev[nxt] = bba_pkg::LinkW'(g);
    bin_head[k] = bba_pkg::LinkW'(g);
    bin_map[k]  = 1'b1;
  endfunction

  function automatic void unlink_free(int unsigned g, int unsigned k);
    logic [bba_pkg::LinkW-1:0] p, n;
    if (g >= bba_pkg::NumGran || k >= bba_pkg::NumBins) return;
    p = link_prev[g];
    n = link_next[g];
    if (p < bba_pkg::NumGran) begin
      link_next[p] = n;
    end else begin
      bin_head[k] = n;
      if (n >= bba_pkg::NumGran) bin_map[k] = 1'b0;
    end
    if (n < bba_pkg::NumGran) link_prev[n] = p;
    gran_free[g] = 1'b0;
  endfunction

  function automatic void clear_arena(logic [bba_pkg::OrdW-1:0] ord);
    arena_ord = ord;
    bin_map   = '0;
    for (int k = 0; k < bba_pkg::NumBins; k++) bin_head[k] = bba_pkg::LinkNull;
    for (int g = 0; g < bba_pkg::NumGran; g++) begin
      gran_free[g] = 1'b0;
      gran_ord[g]  = '0;
      link_prev[g] = '0;
      link_next[g] = '0;
    end
    push_free(0, ord - bba_pkg::MinOrd);
  endfunction

  function automatic bba_pkg::out_word_t predict_alloc(logic [bba_pkg::SizeW-1:0] size);
    bba_pkg::out_word_t          r;
    longint                      total;
    longint                      v;
    int unsigned                 t, idx, found, g;
    logic [bba_pkg::NumBins-1:0] avail;
    r = '0;
    total = longint'(size) + bba_pkg::HdrBytes;
    if (size == 0 || total > (64'd1 << bba_pkg::MaxOrd)) return r;
    if (total <= (64'd1 << bba_pkg::MinOrd)) begin
      t = bba_pkg::MinOrd;
    end else begin
      v = total - 1;
      t = 0;
      while (v != 0) begin
        t++;
        v = v >> 1;
      end
      if (t > bba_pkg::MaxOrd) t = bba_pkg::MaxOrd;
    end
    idx = t - bba_pkg::MinOrd;
    avail = bin_map & ({bba_pkg::NumBins{1'b1}} << idx);
    if (avail == '0) return r;
    found = 0;
    while (!avail[found]) found++;
    g = bin_head[found];
    if (g >= bba_pkg::NumGran) return r;
    unlink_free(g, found);
    for (int unsigned k = found; k > idx; k--) push_free(g ^ (1 << (k - 1)), k - 1);
    gran_ord[g]  = bba_pkg::BinW'(idx);
    gran_free[g] = 1'b0;
    r.granted_offset = bba_pkg::OffW'((g << bba_pkg::MinOrd) + bba_pkg::HdrBytes);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic bba_pkg::out_word_t predict_free(logic [bba_pkg::OffW-1:0] uoff);
    bba_pkg::out_word_t r;
    int unsigned        b, g, k, top, bud;
    r = '0;
    if (uoff < bba_pkg::HdrBytes) return r;
    b = uoff - bba_pkg::HdrBytes;
    if ((b & ((1 << bba_pkg::MinOrd) - 1)) != 0) return r;
    if (b >= (1 << arena_ord)) return r;
    g = b >> bba_pkg::MinOrd;
    if (g >= bba_pkg::NumGran || gran_free[g]) return r;
    top = arena_ord - bba_pkg::MinOrd;
    k = gran_ord[g];
    if (k > top || (g & ((1 << k) - 1)) != 0) return r;
    while (k < top) begin
      bud = g ^ (1 << k);
      if (bud >= bba_pkg::NumGran || !gran_free[bud] || gran_ord[bud] != k) break;
      unlink_free(bud, k);
      if (bud < g) g = bud;
      k++;
    end
    push_free(g, k);
    r.ok = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails     = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bba_pkg::out_word_t       want;
    logic [bba_pkg::OrdW-1:0] v;
    if (!rst_ni) begin
      expected_words.delete();
      clear_arena(bba_pkg::OrdW'(bba_pkg::MaxOrd));
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_word_o, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.granted_offset !== want.granted_offset)
            report_mismatch("granted_offset", out_word_o.granted_offset,
                            want.granted_offset);
          if (out_word_o.ok !== want.ok)
            report_mismatch("ok", out_word_o.ok, want.ok);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_word_i.operation == bba_pkg::OP_ALLOC)
          expected_words.push_back(predict_alloc(in_word_i.request_size));
        else
          expected_words.push_back(predict_free(in_word_i.user_offset));
      end
      // register index is the word address bit
      if (psel && penable && pwrite && pready && paddr[2] == RegArenaOrder[2]) begin
        v = pwdata[bba_pkg::OrdW-1:0];
        if (v < bba_pkg::MinOrd) v = bba_pkg::OrdW'(bba_pkg::MinOrd);
        if (v > bba_pkg::MaxOrd) v = bba_pkg::OrdW'(bba_pkg::MaxOrd);
        clear_arena(v);
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ----- verif/tb_buddy_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_unit
// Drives allocate and free words through the allocator over several arena
// sizes with random idling on both channels; bba_checker predicts results.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegArenaOrder = 3'd0;
  localparam int         StuckLimit    = 12000;
  localparam int         PhaseWords    = 280;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  bba_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bba_pkg::out_word_t out_word_o;
  int                 fail_count, pending;

  int          send_idle_pct = 37, recv_idle_pct = 62;
  bit          quiet;                // stretch with no idling
  int          stuck_cycles = 0;
  logic [bba_pkg::OffW-1:0] live_offsets[$];
  bba_pkg::op_e             ops_in_flight[$];

  buddy_block_allocator_unit u_dut (.*);

  bba_checker u_chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o, .out_stall_i, .out_word_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) quiet <= ($urandom_range(0, 3) == 0);
    out_stall_i <= !quiet && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // track granted offsets so that frees mostly hit live blocks
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o)
      ops_in_flight.push_back(bba_pkg::op_e'(in_word_i.operation));
    if (out_valid_o && !out_stall_i && ops_in_flight.size() != 0) begin
      if (ops_in_flight.pop_front() == bba_pkg::OP_ALLOC && out_word_o.ok)
        live_offsets.push_back(out_word_o.granted_offset);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(bba_pkg::op_e op, logic [bba_pkg::SizeW-1:0] size,
                           logic [bba_pkg::OffW-1:0] uoff);
    bba_pkg::in_word_t w;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    w.operation    = op;
    w.request_size = size;
    w.user_offset  = uoff;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending != 0 || ops_in_flight.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_arena_order(logic [31:0] value);
    drain_outputs();
    repeat (45) @(negedge clk_i);   // idle gap before the register write
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegArenaOrder; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    live_offsets.delete();
  endtask

  task automatic send_random();
    int sel, idx;
    logic [bba_pkg::SizeW-1:0] size;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      case ($urandom_range(0, 19))
        0:       size = bba_pkg::SizeW'($urandom());
        1, 2:    size = bba_pkg::SizeW'($urandom_range(1, 16384));
        default: size = bba_pkg::SizeW'($urandom_range(1, 600));
      endcase
      send_word(bba_pkg::OP_ALLOC, size, bba_pkg::OffW'($urandom()));
    end else if (sel < 90 && live_offsets.size() != 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      send_word(bba_pkg::OP_FREE, bba_pkg::SizeW'($urandom()), live_offsets[idx]);
      live_offsets.delete(idx);
    end else if (sel < 95) begin
      send_word(bba_pkg::OP_FREE, bba_pkg::SizeW'($urandom()),
                bba_pkg::OffW'($urandom()));
    end else begin
      // granule aligned, may be interior or stale
      send_word(bba_pkg::OP_FREE, bba_pkg::SizeW'($urandom()),
                bba_pkg::OffW'(($urandom_range(0, 2047) << bba_pkg::MinOrd) +
                               bba_pkg::HdrBytes));
    end
  endtask

  initial begin
    logic [31:0] orders[4];
    int n;
    orders = '{32'd0, 32'd10, 32'd31, 32'd12};
    quiet = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: refusals, exact fits, whole arena, exhaustion, bad frees
    send_word(bba_pkg::OP_ALLOC, '0, '0);
    send_word(bba_pkg::OP_ALLOC, 20'hFFFFF, '1);
    send_word(bba_pkg::OP_ALLOC, 20'd65529, '0);
    send_word(bba_pkg::OP_ALLOC, 20'd65528, '0);
    send_word(bba_pkg::OP_ALLOC, 20'd1, '0);
    send_word(bba_pkg::OP_FREE, '0, 16'd8);
    send_word(bba_pkg::OP_FREE, '0, 16'd8);
    send_word(bba_pkg::OP_FREE, '0, 16'd0);
    send_word(bba_pkg::OP_FREE, '0, 16'd9);
    send_word(bba_pkg::OP_ALLOC, 20'd24, '0);
    send_word(bba_pkg::OP_ALLOC, 20'd25, '0);
    send_word(bba_pkg::OP_ALLOC, 20'd1, '0);
    send_word(bba_pkg::OP_FREE, '0, 16'd72);
    send_word(bba_pkg::OP_FREE, '0, 16'd40);
    send_word(bba_pkg::OP_FREE, '0, 16'd8);
    send_word(bba_pkg::OP_FREE, '0, 16'hFFFF);
    drain_outputs();
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) write_arena_order(orders[ph-1]);
      for (int i = 0; i < PhaseWords; i++) begin
        if (n == 470) begin
          send_idle_pct = 62;
          recv_idle_pct = 37;
        end else if (n == 940) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 700) drain_outputs();
        send_random();
        n++;
      end
    end
    drain_outputs();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
